// ===== hw/rtl/palette_allocate_nearest_core_macros.svh =====
// Assertion macros for the palette allocator.
// Used by the top level only; no other dependencies.
`ifndef PALETTE_ALLOCATE_NEAREST_CORE_MACROS_SVH
`define PALETTE_ALLOCATE_NEAREST_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define PAN_ASSERT_IMP(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
		else $error("pan assertion failed");
// next-cycle implication
`define PAN_ASSERT_NXT(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
		else $error("pan assertion failed");
`else
`define PAN_ASSERT_IMP(lbl, clk, rstn, pre, post)
`define PAN_ASSERT_NXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== hw/rtl/pan_pkg.sv =====
// Shared constants, types and helper functions for the palette allocator.
// No dependencies.
`timescale 1ns / 1ps
package pan_pkg;
	localparam int PAL_ENTRIES  = 256;
	localparam int PAL_IDX_W    = $clog2(PAL_ENTRIES);
	localparam int RAMP_ENTRIES = 64;
	localparam int RAMP_BASE    = PAL_ENTRIES - RAMP_ENTRIES;
	localparam int COLOUR_W     = 24;
	localparam int CHAN_W       = 8;
	localparam int PIXEL_W      = 8;
	localparam int SQ_W         = 2 * CHAN_W;
	localparam int DIST_W       = SQ_W + 3;

	typedef logic [PAL_IDX_W-1:0] pal_idx_t;
	typedef logic [COLOUR_W-1:0]  colour_t;
	typedef logic [CHAN_W-1:0]    chan_t;
	typedef logic [SQ_W-1:0]      sq_t;
	typedef logic [DIST_W-1:0]    dist_t;
	typedef logic [PIXEL_W-1:0]   pixel_t;

	// controller -> datapath
	typedef struct packed {
		logic     start;
		logic     issue;
		pal_idx_t addr;
		logic     finish;
	} pan_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} pan_sts_t;

	// fixed ramp in the top entries: each 2-bit channel times 0x55
	function automatic colour_t ramp_colour(pal_idx_t idx);
		pal_idx_t k;
		k = idx - PAL_IDX_W'(RAMP_BASE);
		return {{4{k[5:4]}}, {4{k[3:2]}}, {4{k[1:0]}}};
	endfunction

	function automatic logic [PAL_ENTRIES-1:0] valid_reset();
		logic [PAL_ENTRIES-1:0] v;
		v = '0;
		for (int i = RAMP_BASE; i < PAL_ENTRIES; i++) begin
			v[i] = 1'b1;
		end
		return v;
	endfunction

	function automatic chan_t abs_diff(chan_t a, chan_t b);
		return (a > b) ? (a - b) : (b - a);
	endfunction
endpackage

// ===== hw/rtl/pan_colour_if.sv =====
// Request channel: one colour per beat.
// Depends on pan_pkg.
`timescale 1ns / 1ps
interface pan_colour_if;
	import pan_pkg::*;
	logic    valid;
	logic    ready;
	colour_t rgb_colour;
	modport source(output valid, output rgb_colour, input ready);
	modport sink(input valid, input rgb_colour, output ready);
endinterface

// ===== hw/rtl/pan_pixel_if.sv =====
// Response channel: one palette index per beat.
// Depends on pan_pkg.
`timescale 1ns / 1ps
interface pan_pixel_if;
	import pan_pkg::*;
	logic   valid;
	logic   ready;
	pixel_t pixel_value;
	modport source(output valid, output pixel_value, input ready);
	modport sink(input valid, input pixel_value, output ready);
endinterface

// ===== hw/rtl/pan_ctrl.sv =====
// Sequencer: accepts a request, sweeps the palette address, drains, finishes.
// Depends on pan_pkg.
`timescale 1ns / 1ps
module pan_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  pan_pkg::pan_sts_t sts,
	output pan_pkg::pan_cmd_t cmd
);
	import pan_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t   state_q;
	logic     ready_q;
	pal_idx_t addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
			addr_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid && ready_q) begin
						state_q <= ST_SCAN;
						ready_q <= 1'b0;
						addr_q  <= PAL_IDX_W'(PAL_ENTRIES - 1);
					end
				end
				ST_SCAN: begin
					if (addr_q == '0) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q - pal_idx_t'(1);
					end
				end
				ST_DRAIN: begin
					if (!sts.pipe_busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign req_ready  = ready_q;
	assign cmd.start  = req_valid & ready_q;
	assign cmd.issue  = (state_q == ST_SCAN);
	assign cmd.addr   = addr_q;
	assign cmd.finish = (state_q == ST_FINISH) & sts.out_free;
endmodule

// ===== hw/rtl/pan_datapath.sv =====
// Palette store, two-stage compare/distance pipeline, trackers, result register.
// Depends on pan_pkg.
`timescale 1ns / 1ps
module pan_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  pan_pkg::colour_t  rgb_colour,
	input  pan_pkg::pan_cmd_t cmd,
	output pan_pkg::pan_sts_t sts,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output pan_pkg::pixel_t   pixel_value
);
	import pan_pkg::*;

	colour_t                mem [PAL_ENTRIES];
	logic [PAL_ENTRIES-1:0] valid_q;
	colour_t                want_q;

	// stage 1: registered read
	colour_t  mem_rd_s1;
	pal_idx_t idx_s1;
	logic     vld_s1;
	logic     pv_s1;
	colour_t  colour_s1;

	// stage 2: compare and squares
	logic     match_s2;
	sq_t      sq_r_s2;
	sq_t      sq_g_s2;
	sq_t      sq_b_s2;
	pal_idx_t idx_s2;
	logic     vld_s2;
	logic     pv_s2;
	dist_t    dist_s2;

	// trackers
	logic     found_q;
	pal_idx_t found_idx_q;
	logic     empty_q;
	pal_idx_t empty_idx_q;
	dist_t    best_dist_q;
	pal_idx_t best_idx_q;

	logic     rsp_valid_q;
	pixel_t   pixel_q;
	logic     alloc;
	chan_t    d_r;
	chan_t    d_g;
	chan_t    d_b;

	assign alloc = cmd.finish & ~found_q & empty_q;

	always_ff @(posedge clk) begin
		if (alloc) begin
			mem[empty_idx_q] <= want_q;
		end
		mem_rd_s1 <= mem[cmd.addr];
	end

	// top entries hold the fixed ramp and are never written
	assign colour_s1 = (idx_s1 >= PAL_IDX_W'(RAMP_BASE)) ? ramp_colour(idx_s1) : mem_rd_s1;

	assign d_r = abs_diff(colour_s1[7:0],   want_q[7:0]);
	assign d_g = abs_diff(colour_s1[15:8],  want_q[15:8]);
	assign d_b = abs_diff(colour_s1[23:16], want_q[23:16]);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			want_q <= rgb_colour;
		end
		idx_s1   <= cmd.addr;
		vld_s1   <= valid_q[cmd.addr];
		match_s2 <= (colour_s1 == want_q);
		sq_r_s2  <= SQ_W'(d_r) * SQ_W'(d_r);
		sq_g_s2  <= SQ_W'(d_g) * SQ_W'(d_g);
		sq_b_s2  <= SQ_W'(d_b) * SQ_W'(d_b);
		idx_s2   <= idx_s1;
		vld_s2   <= vld_s1;
	end

	// 3*dG^2 + dB^2 + 2*dR^2
	assign dist_s2 = (DIST_W'(sq_g_s2) << 1) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2)
		+ (DIST_W'(sq_r_s2) << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1       <= 1'b0;
			pv_s2       <= 1'b0;
			found_q     <= 1'b0;
			empty_q     <= 1'b0;
			found_idx_q <= '0;
			empty_idx_q <= '0;
			best_dist_q <= '1;
			best_idx_q  <= '0;
			valid_q     <= valid_reset();
			rsp_valid_q <= 1'b0;
			pixel_q     <= '0;
		end else begin
			pv_s1 <= cmd.issue;
			pv_s2 <= pv_s1;
			if (cmd.start) begin
				found_q     <= 1'b0;
				empty_q     <= 1'b0;
				best_dist_q <= '1;
			end else if (pv_s2) begin
				// sweep runs high to low: first match is the highest,
				// last empty the lowest, strict compare keeps the highest tie
				if (vld_s2 && match_s2 && !found_q) begin
					found_q     <= 1'b1;
					found_idx_q <= idx_s2;
				end
				if (!vld_s2) begin
					empty_q     <= 1'b1;
					empty_idx_q <= idx_s2;
				end
				if (dist_s2 < best_dist_q) begin
					best_dist_q <= dist_s2;
					best_idx_q  <= idx_s2;
				end
			end
			if (alloc) begin
				valid_q[empty_idx_q] <= 1'b1;
			end
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
				if (found_q) begin
					pixel_q <= PIXEL_W'(found_idx_q);
				end else if (empty_q) begin
					pixel_q <= PIXEL_W'(empty_idx_q);
				end else begin
					pixel_q <= PIXEL_W'(best_idx_q);
				end
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign sts.pipe_busy = pv_s1 | pv_s2;
	assign sts.out_free  = ~rsp_valid_q | rsp_ready;
	assign rsp_valid     = rsp_valid_q;
	assign pixel_value   = pixel_q;
endmodule

// ===== hw/rtl/palette_allocate_nearest_core.sv =====
// Channel | Role | Payload                     | Handshake
// req     | sink   | rgb_colour [23:0] B,G,R  | valid/ready, beat on both high
// rsp     | source | pixel_value [7:0]        | valid/ready, beat on both high
//
// Each request sweeps every palette entry once, one entry per cycle through the
// single read port of the palette store, then drains the two-stage pipeline;
// only one request is swept at a time.
// Reset is immediate: per-entry valid flags load the ramp pattern, no clearing pass.
// A finished response waits in its output register; a new request is taken
// meanwhile, and that request's finish stalls only until the register frees.
// Depends on pan_pkg, pan_colour_if, pan_pixel_if, pan_ctrl, pan_datapath and
// the macros header.
`timescale 1ns / 1ps
`include "palette_allocate_nearest_core_macros.svh"
module palette_allocate_nearest_core (
	input logic          clk,
	input logic          arst_n,
	pan_colour_if.sink   req,
	pan_pixel_if.source  rsp
);
	import pan_pkg::*;

	pan_cmd_t cmd;
	pan_sts_t sts;

	// sequencer: request beat, address sweep, drain, finish
	pan_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// palette store, match / empty / nearest trackers, response register
	pan_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.rgb_colour  (req.rgb_colour),
		.cmd         (cmd),
		.sts         (sts),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.pixel_value (rsp.pixel_value)
	);

	// no second request while one is in flight
	`PAN_ASSERT_NXT(a_busy_after_req, clk, arst_n, req.valid && req.ready, !req.ready)
	`PAN_ASSERT_IMP(a_no_req_in_sweep, clk, arst_n, cmd.issue, !req.ready)
	// trackers are only reset with the pipeline empty
	`PAN_ASSERT_IMP(a_start_pipe_idle, clk, arst_n, cmd.start, !sts.pipe_busy)
	// finishing always presents a response
	`PAN_ASSERT_NXT(a_finish_rsp, clk, arst_n, cmd.finish, rsp.valid)
endmodule
